// File: sv/cpio_newc_stream_parser_unit_assert.svh
// Assertion macros used by the checker file of the cpio newc parser.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef CPIO_NEWC_STREAM_PARSER_UNIT_ASSERT_SVH
`define CPIO_NEWC_STREAM_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CNSP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CNSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/cnsp_pkg.sv
// ----------------------------------------------------------------------------
// cnsp_pkg
// Shared types, codes and character tables of the cpio newc stream parser.
// ----------------------------------------------------------------------------
`default_nettype none

package cnsp_pkg;

  typedef enum logic [2:0] {
    PH_MAGIC   = 3'd0,
    PH_HEADER  = 3'd1,
    PH_NAME    = 3'd2,
    PH_NAMEPAD = 3'd3,
    PH_DATA    = 3'd4,
    PH_DATAPAD = 3'd5,
    PH_DONE    = 3'd6
  } phase_t;

  // Result kinds
  localparam logic [2:0] KIND_NAME_BYTE   = 3'd0;
  localparam logic [2:0] KIND_DATA_BYTE   = 3'd1;
  localparam logic [2:0] KIND_HEADER_DONE = 3'd2;
  localparam logic [2:0] KIND_ARCHIVE_END = 3'd3;
  localparam logic [2:0] KIND_BAD_MAGIC   = 3'd4;
  localparam logic [2:0] KIND_BAD_HEX     = 3'd5;

  localparam logic [3:0]  HEADER_FIELDS    = 4'd13;
  localparam logic [3:0]  FILESIZE_FIELD   = 4'd6;
  localparam logic [3:0]  NAMESIZE_FIELD   = 4'd11;
  localparam logic [31:0] MAGIC_LEN        = 32'd6;
  localparam logic [31:0] DIGITS_PER_FIELD = 32'd8;
  localparam logic [31:0] TRAILER_LEN      = 32'd9;
  // The 110-byte header leaves 2 modulo 4 ahead of the name
  localparam logic [1:0]  NAME_PAD_BIAS    = 2'd2;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  byte_value;
    logic        last;
    logic [31:0] entry_file_size;
    logic [31:0] entry_name_size;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_digit(input logic [7:0] b);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.val = 4'(b - 8'h30);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      h.val = 4'(b - 8'h37);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      h.val = 4'(b - 8'h57);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  // "070701"
  function automatic logic [7:0] magic_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd1, 3'd3: c = 8'h37;
      3'd5:       c = 8'h31;
      default:    c = 8'h30;
    endcase
    return c;
  endfunction

  // "TRAILER!!"
  function automatic logic [7:0] trailer_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:       c = 8'h54;
      4'd1, 4'd6: c = 8'h52;
      4'd2:       c = 8'h41;
      4'd3:       c = 8'h49;
      4'd4:       c = 8'h4C;
      4'd5:       c = 8'h45;
      default:    c = 8'h21;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: sv/cpio_newc_stream_parser_unit.sv
// ----------------------------------------------------------------------------
// cpio_newc_stream_parser_unit
// Byte-stream parser for cpio newc archives with a buffered result channel.
// ----------------------------------------------------------------------------
// Usage:
//   Feed the archive on in_archive_byte, starting at an entry header, with
//   the in_valid / in_ready handshake. Each accepted byte causes zero or one
//   result on the out_ channel: a name byte, a data byte, header complete,
//   archive end, bad magic or bad hex digit, together with the sizes of the
//   current entry. Matching magic bytes and padding bytes produce no result.
//   Each result is registered into the output register, or into the skid
//   entry while the output is stalled. Throughput: one byte per cycle while
//   the skid entry is free; the parser core updates its state on each byte.
//   Stalls: the output register plus one skid entry let one more byte be
//   taken while a result waits; in_ready drops only while the skid entry
//   is occupied.
//   Reset (rst_n low, synchronous) returns the parser to the magic check of
//   a new entry, zeroes the sizes and empties the result buffer. After archive
//   end or an error, further bytes are consumed without results until reset.
// ----------------------------------------------------------------------------
`default_nettype none

module cpio_newc_stream_parser_unit
  import cnsp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_archive_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_kind,
  output logic [7:0]       out_byte_value,
  output logic             out_last,
  output logic [31:0]      out_entry_file_size,
  output logic [31:0]      out_entry_name_size
);

  logic    accept;
  logic    res_valid;
  result_t res;
  logic    out_free;
  logic    out_valid_r;
  logic    skid_valid_r;
  result_t out_r;
  result_t skid_r;

  assign in_ready = !skid_valid_r;
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  cnsp_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (accept),
    .archive_byte (in_archive_byte),
    .res_valid    (res_valid),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r  <= skid_valid_r || res_valid;
      skid_valid_r <= 1'b0;
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload: the skid entry drains first, so order is kept
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (res_valid) begin
        out_r <= res;
      end
    end else if (res_valid) begin
      skid_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_kind            = out_r.kind;
  assign out_byte_value      = out_r.byte_value;
  assign out_last            = out_r.last;
  assign out_entry_file_size = out_r.entry_file_size;
  assign out_entry_name_size = out_r.entry_name_size;

endmodule

`default_nettype wire

// File: sv/cnsp_core.sv
// ----------------------------------------------------------------------------
// cnsp_core
// Parser state and per-byte decode: one archive byte per step, at most one
// result per step.
// ----------------------------------------------------------------------------
`default_nettype none

module cnsp_core
  import cnsp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] archive_byte,
  output logic            res_valid,
  output result_t         res
);

  phase_t      phase_r, phase_nxt;
  logic [31:0] phase_count_r, phase_count_nxt;
  logic [31:0] hex_acc_r, hex_acc_nxt;
  logic [3:0]  field_r, field_nxt;
  logic [31:0] name_length_r, name_length_nxt;
  logic [31:0] data_length_r, data_length_nxt;
  logic [1:0]  align_r, align_nxt;
  logic        tmatch_r, tmatch_nxt;

  // Shared decode terms
  logic [31:0] count_inc;
  logic [2:0]  magic_idx;
  logic        magic_ok;
  hex_t        hex;
  logic [31:0] hex_shift;
  logic        field_end;
  logic [3:0]  field_inc;
  logic        header_end;
  logic        tmatch_upd;
  logic        trailer_hit;
  logic        name_last;
  logic        data_last;
  logic [1:0]  name_pad;
  logic [1:0]  data_pad;

  assign count_inc   = phase_count_r + 32'd1;
  assign magic_idx   = (phase_count_r < MAGIC_LEN) ? phase_count_r[2:0] : 3'd0;
  assign magic_ok    = (archive_byte == magic_char(magic_idx));
  assign hex         = hex_digit(archive_byte);
  assign hex_shift   = {hex_acc_r[27:0], hex.val};
  assign field_end   = (count_inc >= DIGITS_PER_FIELD);
  assign field_inc   = field_r + 4'd1;
  assign header_end  = (field_inc >= HEADER_FIELDS);
  assign tmatch_upd  = tmatch_r &
                       !((phase_count_r < TRAILER_LEN) &&
                         (archive_byte != trailer_char(phase_count_r[3:0])));
  assign trailer_hit = (phase_count_r == TRAILER_LEN - 32'd1) && tmatch_upd;
  assign name_last   = (count_inc == name_length_r);
  assign data_last   = (count_inc == data_length_r);
  assign name_pad    = 2'd0 - (NAME_PAD_BIAS + name_length_r[1:0]);
  assign data_pad    = 2'd0 - data_length_r[1:0];

  // Next state
  always_comb begin
    logic go_after_name;
    logic go_after_name_pad;
    logic go_after_data;
    logic go_start;
    phase_nxt         = phase_r;
    phase_count_nxt   = phase_count_r;
    hex_acc_nxt       = hex_acc_r;
    field_nxt         = field_r;
    name_length_nxt   = name_length_r;
    data_length_nxt   = data_length_r;
    align_nxt         = align_r;
    tmatch_nxt        = tmatch_r;
    go_after_name     = 1'b0;
    go_after_name_pad = 1'b0;
    go_after_data     = 1'b0;
    go_start          = 1'b0;

    unique case (phase_r)
      PH_MAGIC: begin
        if (!magic_ok) begin
          phase_nxt = PH_DONE;
        end else if (count_inc >= MAGIC_LEN) begin
          phase_nxt       = PH_HEADER;
          phase_count_nxt = 32'd0;
          field_nxt       = 4'd0;
          hex_acc_nxt     = 32'd0;
        end else begin
          phase_count_nxt = count_inc;
        end
      end
      PH_HEADER: begin
        if (!hex.ok) begin
          phase_nxt = PH_DONE;
        end else if (!field_end) begin
          hex_acc_nxt     = hex_shift;
          phase_count_nxt = count_inc;
        end else begin
          if (field_r == FILESIZE_FIELD) data_length_nxt = hex_shift;
          if (field_r == NAMESIZE_FIELD) name_length_nxt = hex_shift;
          phase_count_nxt = 32'd0;
          hex_acc_nxt     = 32'd0;
          field_nxt       = field_inc;
          if (header_end) begin
            field_nxt  = 4'd0;
            tmatch_nxt = 1'b1;
            if (name_length_r != 32'd0) begin
              phase_nxt = PH_NAME;
            end else begin
              go_after_name = 1'b1;
            end
          end
        end
      end
      PH_NAME: begin
        tmatch_nxt = tmatch_upd;
        if (trailer_hit) begin
          phase_nxt = PH_DONE;
        end else begin
          phase_count_nxt = count_inc;
          go_after_name   = name_last;
        end
      end
      PH_NAMEPAD: begin
        align_nxt         = align_r - 2'd1;
        go_after_name_pad = (align_r == 2'd1);
      end
      PH_DATA: begin
        phase_count_nxt = count_inc;
        go_after_data   = data_last;
      end
      PH_DATAPAD: begin
        align_nxt = align_r - 2'd1;
        go_start  = (align_r == 2'd1);
      end
      default: begin
        phase_nxt = PH_DONE;
      end
    endcase

    // Resolve entry boundaries; zero sizes and zero padding fall through
    if (go_after_name) begin
      if (name_pad != 2'd0) begin
        phase_nxt = PH_NAMEPAD;
        align_nxt = name_pad;
      end else begin
        go_after_name_pad = 1'b1;
      end
    end
    if (go_after_name_pad) begin
      if (data_length_r != 32'd0) begin
        phase_nxt       = PH_DATA;
        phase_count_nxt = 32'd0;
      end else begin
        go_after_data = 1'b1;
      end
    end
    if (go_after_data) begin
      if (data_pad != 2'd0) begin
        phase_nxt = PH_DATAPAD;
        align_nxt = data_pad;
      end else begin
        go_start = 1'b1;
      end
    end
    if (go_start) begin
      phase_nxt       = PH_MAGIC;
      phase_count_nxt = 32'd0;
      hex_acc_nxt     = 32'd0;
      field_nxt       = 4'd0;
      tmatch_nxt      = 1'b1;
    end
  end

  // Result outputs
  always_comb begin
    res_valid           = 1'b0;
    res.kind            = KIND_NAME_BYTE;
    res.byte_value      = 8'd0;
    res.last            = 1'b0;
    res.entry_file_size = data_length_nxt;
    res.entry_name_size = name_length_nxt;
    unique case (phase_r)
      PH_MAGIC: begin
        if (!magic_ok) begin
          res_valid = step;
          res.kind  = KIND_BAD_MAGIC;
        end
      end
      PH_HEADER: begin
        if (!hex.ok) begin
          res_valid = step;
          res.kind  = KIND_BAD_HEX;
        end else if (field_end && header_end) begin
          res_valid = step;
          res.kind  = KIND_HEADER_DONE;
        end
      end
      PH_NAME: begin
        res_valid = step;
        if (trailer_hit) begin
          res.kind = KIND_ARCHIVE_END;
        end else begin
          res.kind       = KIND_NAME_BYTE;
          res.byte_value = archive_byte;
          res.last       = name_last;
        end
      end
      PH_DATA: begin
        res_valid      = step;
        res.kind       = KIND_DATA_BYTE;
        res.byte_value = archive_byte;
        res.last       = data_last;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_MAGIC;
      phase_count_r <= 32'd0;
      hex_acc_r     <= 32'd0;
      field_r       <= 4'd0;
      name_length_r <= 32'd0;
      data_length_r <= 32'd0;
      align_r       <= 2'd0;
      tmatch_r      <= 1'b1;
    end else if (step) begin
      phase_r       <= phase_nxt;
      phase_count_r <= phase_count_nxt;
      hex_acc_r     <= hex_acc_nxt;
      field_r       <= field_nxt;
      name_length_r <= name_length_nxt;
      data_length_r <= data_length_nxt;
      align_r       <= align_nxt;
      tmatch_r      <= tmatch_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/cnsp_checker.sv
// ----------------------------------------------------------------------------
// cnsp_checker
// Port-level checks of the cpio newc stream parser, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cpio_newc_stream_parser_unit_assert.svh"

module cnsp_checker
  import cnsp_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_kind,
  input wire logic [7:0]  out_byte_value,
  input wire logic        out_last
);

  logic        is_byte_kind;
  logic        is_final_kind;
  logic        status_out;
  logic        no_byte_data;
  logic        final_taken;
  logic        out_stalled;
  logic [11:0] out_shown;

  assign is_byte_kind  = (out_kind == KIND_NAME_BYTE) || (out_kind == KIND_DATA_BYTE);
  assign is_final_kind = (out_kind == KIND_ARCHIVE_END) || (out_kind == KIND_BAD_MAGIC) ||
                         (out_kind == KIND_BAD_HEX);
  assign status_out    = out_valid && !is_byte_kind;
  assign no_byte_data  = (out_byte_value == 8'd0) && !out_last;
  assign final_taken   = out_valid && out_ready && is_final_kind;
  assign out_stalled   = out_valid && !out_ready;
  assign out_shown     = {out_kind, out_byte_value, out_last};

  // Status results carry no byte and no last flag
  `CNSP_ASSERT_NOW(a_status_clean, status_out, no_byte_data, "status result carries byte data")

  // Input stalls only while a result is backed up
  `CNSP_ASSERT_NOW(a_stall_cause, !in_ready, out_valid, "input stalled with empty output")

  // Nothing follows an end or error result
  `CNSP_ASSERT_NEXT(a_final_is_last, final_taken, !out_valid, "result after archive end or error")

  // Stalled result holds
  `CNSP_ASSERT_NEXT(a_out_hold, out_stalled, out_valid && $stable(out_shown), "held result changed")

endmodule

bind cpio_newc_stream_parser_unit cnsp_checker u_cnsp_checker (.*);

`default_nettype wire

// File: tb/cpio_newc_stream_parser_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cpio_newc_stream_parser_unit_test
// Self-checking testbench for the cpio newc stream parser. A queue of archive
// bytes (directed entries, a long run of random well-formed entries and one
// terminating case) feeds a valid/ready driver. A byte-level parser model
// predicts each result, and a monitor compares every result transaction with
// the oldest prediction. Both sides idle at random, and the receiver holds off
// for long stretches to fill the result buffer and stall the input.
// ----------------------------------------------------------------------------

module cpio_newc_stream_parser_unit_test;
  import cnsp_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 5;
  localparam int RANDOM_BYTES = 650;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 150;
  localparam int IDLE_PCT     = 24;
  localparam int unsigned CAP_ALL = 32'hFFFF_FFFF;

  localparam logic [47:0] MAGIC_TEXT   = "070701";
  localparam logic [71:0] TRAILER_TEXT = "TRAILER!!";
  // Characters just outside the hex digit ranges
  localparam logic [47:0] NEAR_HEX     = "/:@G`g";

  typedef enum int {CASE_UPPER, CASE_LOWER, CASE_MIXED} hex_case_t;
  typedef enum int {FILL_ZERO, FILL_ONES, FILL_RANDOM} fill_t;
  typedef enum int {
    END_TRAILER, END_BAD_MAGIC, END_BAD_HEX, END_LONG_DATA, END_LONG_NAME
  } ending_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_archive_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_kind;
  logic [7:0]  out_byte_value;
  logic        out_last;
  logic [31:0] out_entry_file_size;
  logic [31:0] out_entry_name_size;

  cpio_newc_stream_parser_unit i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_archive_byte     (in_archive_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_kind            (out_kind),
    .out_byte_value      (out_byte_value),
    .out_last            (out_last),
    .out_entry_file_size (out_entry_file_size),
    .out_entry_name_size (out_entry_name_size)
  );

  // Parser model state
  phase_t      ps_phase;
  logic [31:0] ps_count;
  logic [31:0] ps_acc;
  logic [3:0]  ps_field;
  logic [31:0] ps_name_len;
  logic [31:0] ps_file_len;
  logic [1:0]  ps_pad;
  logic        ps_trailer_ok;

  result_t     expected_results[$];
  logic [7:0]  archive_bytes[$];

  logic        in_fire = 1'b0;
  int          bytes_taken = 0;
  int          mismatches = 0;
  int          hold_left = 0;
  int          holds_done = 0;
  logic        calm;

  // No idling on either side over this window of the stream
  assign calm = (bytes_taken >= 900) && (bytes_taken < 1200);

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("cpio_newc_stream_parser_unit verification failed");
    $finish;
  end

  // {valid, value} of one ASCII hex digit
  function automatic logic [4:0] decode_hex_char(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
    return 5'b0;
  endfunction

  task automatic begin_entry();
    ps_phase      = PH_MAGIC;
    ps_count      = '0;
    ps_acc        = '0;
    ps_field      = '0;
    ps_trailer_ok = 1'b1;
  endtask

  task automatic leave_data();
    logic [1:0] pad;
    pad = 2'd0 - ps_file_len[1:0];
    if (pad != 2'd0) begin
      ps_phase = PH_DATAPAD;
      ps_pad   = pad;
    end else begin
      begin_entry();
    end
  endtask

  task automatic leave_name_pad();
    if (ps_file_len != 0) begin
      ps_phase = PH_DATA;
      ps_count = '0;
    end else begin
      leave_data();
    end
  endtask

  task automatic leave_name();
    logic [1:0] pad;
    pad = 2'd0 - (ps_name_len[1:0] + NAME_PAD_BIAS);
    if (pad != 2'd0) begin
      ps_phase = PH_NAMEPAD;
      ps_pad   = pad;
    end else begin
      leave_name_pad();
    end
  endtask

  task automatic push_result(input logic [2:0] kind, input logic [7:0] b, input logic last);
    expected_results.push_back(result_t'{kind, b, last, ps_file_len, ps_name_len});
  endtask

  task automatic parse_archive_byte(input logic [7:0] b);
    logic [4:0]  dig;
    logic [31:0] idx;
    logic        last;
    case (ps_phase)
      PH_MAGIC: begin
        if (b != MAGIC_TEXT[8 * (5 - int'(ps_count)) +: 8]) begin
          ps_phase = PH_DONE;
          push_result(KIND_BAD_MAGIC, 8'h00, 1'b0);
        end else begin
          ps_count++;
          if (ps_count == MAGIC_LEN) begin
            ps_phase = PH_HEADER;
            ps_count = '0;
            ps_field = '0;
            ps_acc   = '0;
          end
        end
      end
      PH_HEADER: begin
        dig = decode_hex_char(b);
        if (!dig[4]) begin
          ps_phase = PH_DONE;
          push_result(KIND_BAD_HEX, 8'h00, 1'b0);
        end else begin
          ps_acc = {ps_acc[27:0], dig[3:0]};
          ps_count++;
          if (ps_count == DIGITS_PER_FIELD) begin
            if (ps_field == FILESIZE_FIELD) ps_file_len = ps_acc;
            if (ps_field == NAMESIZE_FIELD) ps_name_len = ps_acc;
            ps_count = '0;
            ps_acc   = '0;
            ps_field = ps_field + 4'd1;
            if (ps_field == HEADER_FIELDS) begin
              ps_field      = '0;
              ps_trailer_ok = 1'b1;
              if (ps_name_len != 0) begin
                ps_phase = PH_NAME;
                ps_count = '0;
              end else begin
                leave_name();
              end
              push_result(KIND_HEADER_DONE, 8'h00, 1'b0);
            end
          end
        end
      end
      PH_NAME: begin
        idx = ps_count;
        if (idx < TRAILER_LEN) begin
          if (b != TRAILER_TEXT[8 * (8 - int'(idx)) +: 8]) ps_trailer_ok = 1'b0;
        end
        if (idx == TRAILER_LEN - 1 && ps_trailer_ok) begin
          // Completed trailer name ends the archive in place of the byte
          ps_phase = PH_DONE;
          push_result(KIND_ARCHIVE_END, 8'h00, 1'b0);
        end else begin
          last     = (idx + 32'd1 == ps_name_len);
          ps_count = idx + 32'd1;
          push_result(KIND_NAME_BYTE, b, last);
          if (last) leave_name();
        end
      end
      PH_NAMEPAD: begin
        ps_pad = ps_pad - 2'd1;
        if (ps_pad == 2'd0) leave_name_pad();
      end
      PH_DATA: begin
        last     = (ps_count + 32'd1 == ps_file_len);
        ps_count = ps_count + 32'd1;
        push_result(KIND_DATA_BYTE, b, last);
        if (last) leave_data();
      end
      PH_DATAPAD: begin
        ps_pad = ps_pad - 2'd1;
        if (ps_pad == 2'd0) begin_entry();
      end
      default: begin
      end
    endcase
  endtask

  task automatic put_magic();
    int i;
    for (i = 0; i < 6; i++) archive_bytes.push_back(MAGIC_TEXT[8 * (5 - i) +: 8]);
  endtask

  task automatic put_hex_field(input logic [31:0] value, input hex_case_t hc);
    logic [3:0] nib;
    logic       upper;
    int         d;
    for (d = 7; d >= 0; d--) begin
      nib   = value[4 * d +: 4];
      upper = (hc == CASE_UPPER) || (hc == CASE_MIXED && $urandom_range(0, 1) == 1);
      if (nib < 4'd10) archive_bytes.push_back(8'(8'h30 + nib));
      else if (upper) archive_bytes.push_back(8'("A" + nib - 8'd10));
      else archive_bytes.push_back(8'("a" + nib - 8'd10));
    end
  endtask

  // Emit one entry; cap limits the name and data bytes, and a part longer
  // than cap ends the stream of this entry right there
  task automatic put_entry(input string prefix, input logic [31:0] name_size,
                           input logic [31:0] file_size, input hex_case_t hc,
                           input fill_t fill, input int unsigned cap);
    logic [31:0] word;
    int unsigned i;
    int unsigned pad;
    put_magic();
    for (i = 0; i < 13; i++) begin
      if (i == FILESIZE_FIELD) word = file_size;
      else if (i == NAMESIZE_FIELD) word = name_size;
      else if (fill == FILL_ZERO) word = '0;
      else if (fill == FILL_ONES) word = '1;
      else word = $urandom;
      put_hex_field(word, hc);
    end
    for (i = 0; i < name_size && i < cap; i++) begin
      if (i < prefix.len()) archive_bytes.push_back(prefix[i]);
      else if (i == name_size - 1) archive_bytes.push_back(8'h00);
      else archive_bytes.push_back(8'($urandom_range(0, 255)));
    end
    if (name_size <= cap) begin
      pad = (4 - (110 + name_size) % 4) % 4;
      repeat (pad) archive_bytes.push_back(8'($urandom_range(0, 255)));
      for (i = 0; i < file_size && i < cap; i++)
        archive_bytes.push_back(8'($urandom_range(0, 255)));
      if (file_size <= cap) begin
        pad = (4 - file_size % 4) % 4;
        repeat (pad) archive_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // Monitor: check result transactions, predict from input transactions
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = result_t'{out_kind, out_byte_value, out_last,
                        out_entry_file_size, out_entry_name_size};
        if (expected_results.size() == 0) begin
          note_mismatch($sformatf("unexpected result kind=%0d byte=%02h last=%0b fsz=%08h nsz=%08h",
                                  got.kind, got.byte_value, got.last,
                                  got.entry_file_size, got.entry_name_size));
        end else begin
          want = expected_results.pop_front();
          if (got.kind !== want.kind || got.byte_value !== want.byte_value ||
              got.last !== want.last || got.entry_file_size !== want.entry_file_size ||
              got.entry_name_size !== want.entry_name_size) begin
            note_mismatch($sformatf({"result mismatch: expected kind=%0d byte=%02h last=%0b ",
                                     "fsz=%08h nsz=%08h, got kind=%0d byte=%02h last=%0b ",
                                     "fsz=%08h nsz=%08h"},
                                    want.kind, want.byte_value, want.last,
                                    want.entry_file_size, want.entry_name_size,
                                    got.kind, got.byte_value, got.last,
                                    got.entry_file_size, got.entry_name_size));
          end
        end
      end
      if (in_valid && in_ready) begin
        parse_archive_byte(in_archive_byte);
        bytes_taken++;
      end
      in_fire <= in_valid && in_ready;
    end
  end

  // Driver: advance to the next byte once the current transaction is taken
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fire)) begin
      if (archive_bytes.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_valid        <= 1'b1;
        in_archive_byte <= archive_bytes.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure plus two long hold-offs
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left == 0 && ((holds_done == 0 && bytes_taken >= 400) ||
                             (holds_done == 1 && bytes_taken >= 1500))) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    string       prefix;
    logic [31:0] nsz;
    logic [31:0] fsz;
    int unsigned base;
    int unsigned pos;
    logic [7:0]  bad;
    ending_t     ending;

    begin_entry();
    ps_name_len = '0;
    ps_file_len = '0;
    ps_pad      = '0;

    // Directed entries: empty sizes, digit cases, near-trailer names
    put_entry("", 0, 0, CASE_UPPER, FILL_ZERO, CAP_ALL);
    put_entry("a", 2, 4, CASE_LOWER, FILL_ONES, CAP_ALL);
    put_entry("", 1, 3, CASE_MIXED, FILL_RANDOM, CAP_ALL);
    put_entry("TRAIL", 6, 1, CASE_UPPER, FILL_ONES, CAP_ALL);
    put_entry("TRAILER!", 8, 0, CASE_LOWER, FILL_RANDOM, CAP_ALL);
    put_entry("TRAILER!", 9, 5, CASE_MIXED, FILL_RANDOM, CAP_ALL);
    put_entry("TRAILER!?", 12, 2, CASE_UPPER, FILL_RANDOM, CAP_ALL);
    put_entry("", 3, 0, CASE_LOWER, FILL_ZERO, CAP_ALL);
    put_entry("", 0, 6, CASE_MIXED, FILL_ONES, CAP_ALL);

    // Random well-formed entries, mostly small
    base = archive_bytes.size();
    while (archive_bytes.size() - base < RANDOM_BYTES) begin
      case ($urandom_range(0, 19))
        0: prefix = "TRAIL";
        1: prefix = "TRAILER";
        2: prefix = "TRAILER!?";
        default: prefix = "";
      endcase
      pos = $urandom_range(0, 9);
      if (pos == 0) nsz = 0;
      else if (pos == 1) nsz = $urandom_range(17, 40);
      else nsz = $urandom_range(1, 16);
      pos = $urandom_range(0, 19);
      if (pos < 3) fsz = 0;
      else if (pos < 6) fsz = $urandom_range(25, 80);
      else fsz = $urandom_range(1, 24);
      put_entry(prefix, nsz, fsz,
                ($urandom_range(0, 9) < 7) ? CASE_MIXED : hex_case_t'($urandom_range(0, 2)),
                FILL_RANDOM, CAP_ALL);
    end

    // One terminating case per run
    ending = ending_t'($urandom_range(0, 4));
    case (ending)
      END_TRAILER: begin
        put_entry("TRAILER!!", $urandom_range(9, 14), 0, CASE_MIXED, FILL_RANDOM, CAP_ALL);
      end
      END_BAD_MAGIC: begin
        pos = $urandom_range(0, 5);
        for (int unsigned i = 0; i < pos; i++)
          archive_bytes.push_back(MAGIC_TEXT[8 * (5 - i) +: 8]);
        do bad = 8'($urandom_range(0, 255)); while (bad == MAGIC_TEXT[8 * (5 - pos) +: 8]);
        archive_bytes.push_back(bad);
      end
      END_BAD_HEX: begin
        put_magic();
        repeat ($urandom_range(0, 12)) put_hex_field($urandom, CASE_MIXED);
        // Keep 0..7 digits of a partial field
        put_hex_field($urandom, CASE_MIXED);
        repeat ($urandom_range(1, 8)) void'(archive_bytes.pop_back());
        if ($urandom_range(0, 1) == 1) begin
          bad = NEAR_HEX[8 * $urandom_range(0, 5) +: 8];
        end else begin
          do bad = 8'($urandom_range(0, 255)); while (decode_hex_char(bad) != 5'b0);
        end
        archive_bytes.push_back(bad);
      end
      END_LONG_DATA: begin
        fsz = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : (32'hF000_0000 | $urandom);
        put_entry("", $urandom_range(1, 12), fsz, CASE_MIXED, FILL_RANDOM, 64);
      end
      default: begin
        nsz = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : (32'hF000_0000 | $urandom);
        put_entry("", nsz, $urandom, CASE_MIXED, FILL_RANDOM, 48);
      end
    endcase
    // Drop into a finished parser, or run on in a long part
    repeat (16) archive_bytes.push_back(8'($urandom_range(0, 255)));

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (archive_bytes.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("cpio_newc_stream_parser_unit verification clean");
    end else begin
      $display("cpio_newc_stream_parser_unit verification failed");
    end
    $finish;
  end

endmodule

// File: cpio_newc_stream_parser_unit.f
+incdir+sv
sv/cnsp_pkg.sv
sv/cnsp_core.sv
sv/cpio_newc_stream_parser_unit.sv
sv/cnsp_checker.sv
tb/cpio_newc_stream_parser_unit_test.sv
